>>> rtl/smac_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// smac_pkg
// Types, formats and the reciprocal table for the Maclaurin sine evaluator.
// ----------------------------------------------------------------------------
package smac_pkg;

  localparam int ANGLE_W = 32;
  localparam int VALUE_W = 40;
  localparam int COUNT_W = 5;
  localparam int WORD_W  = 64;
  localparam int ACC_W   = 128;
  localparam int HALF_W  = 32;

  // angle is Q3.28, working words are Q.48
  localparam int ANGLE_SHIFT = 20;
  localparam int FRAC_SHIFT  = 20;
  localparam int FRAC_BITS   = 48;

  localparam logic [COUNT_W-1:0] TERM_COUNT_RESET = 5'd8;

  localparam logic [WORD_W-1:0] MAG_LIMIT = 64'h7FFF_FFFF_FFFF_FFFF;
  localparam logic [WORD_W-1:0] WORD_MAX  = 64'h7FFF_FFFF_FFFF_FFFF;
  localparam logic [WORD_W-1:0] WORD_MIN  = 64'h8000_0000_0000_0000;
  localparam logic [VALUE_W-1:0] OUT_MAX  = 40'h7F_FFFF_FFFF;
  localparam logic [VALUE_W-1:0] OUT_MIN  = 40'h80_0000_0000;

  localparam logic [2:0] MUL_LAST = 3'd4;

  localparam int RECIP_DEPTH = 32;
  localparam int RECIP_IW    = 5;
  localparam logic [WORD_W-1:0] ONE_Q48 = 64'd1 << FRAC_BITS;

  // round(2^48 / ((2n)(2n+1))), halves up; entry zero unused
  localparam logic [47:0] RECIP_Q48 [RECIP_DEPTH] = '{
    48'd0,
    48'((ONE_Q48 + 64'd3)    / 64'd6),
    48'((ONE_Q48 + 64'd10)   / 64'd20),
    48'((ONE_Q48 + 64'd21)   / 64'd42),
    48'((ONE_Q48 + 64'd36)   / 64'd72),
    48'((ONE_Q48 + 64'd55)   / 64'd110),
    48'((ONE_Q48 + 64'd78)   / 64'd156),
    48'((ONE_Q48 + 64'd105)  / 64'd210),
    48'((ONE_Q48 + 64'd136)  / 64'd272),
    48'((ONE_Q48 + 64'd171)  / 64'd342),
    48'((ONE_Q48 + 64'd210)  / 64'd420),
    48'((ONE_Q48 + 64'd253)  / 64'd506),
    48'((ONE_Q48 + 64'd300)  / 64'd600),
    48'((ONE_Q48 + 64'd351)  / 64'd702),
    48'((ONE_Q48 + 64'd406)  / 64'd812),
    48'((ONE_Q48 + 64'd465)  / 64'd930),
    48'((ONE_Q48 + 64'd528)  / 64'd1056),
    48'((ONE_Q48 + 64'd595)  / 64'd1190),
    48'((ONE_Q48 + 64'd666)  / 64'd1332),
    48'((ONE_Q48 + 64'd741)  / 64'd1482),
    48'((ONE_Q48 + 64'd820)  / 64'd1640),
    48'((ONE_Q48 + 64'd903)  / 64'd1806),
    48'((ONE_Q48 + 64'd990)  / 64'd1980),
    48'((ONE_Q48 + 64'd1081) / 64'd2162),
    48'((ONE_Q48 + 64'd1176) / 64'd2352),
    48'((ONE_Q48 + 64'd1275) / 64'd2550),
    48'((ONE_Q48 + 64'd1378) / 64'd2756),
    48'((ONE_Q48 + 64'd1485) / 64'd2970),
    48'((ONE_Q48 + 64'd1596) / 64'd3192),
    48'((ONE_Q48 + 64'd1711) / 64'd3422),
    48'((ONE_Q48 + 64'd1830) / 64'd3660),
    48'((ONE_Q48 + 64'd1953) / 64'd3906)
  };

  typedef enum logic [2:0] {
    S_IDLE,
    S_PREP,
    S_MUL,
    S_WB,
    S_SUM,
    S_ROUND,
    S_OUT
  } state_t;

  typedef enum logic [1:0] {
    OP_SQUARE,
    OP_XSQ,
    OP_RECIP
  } mul_op_t;

endpackage

>>> rtl/smac_intf.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// smac channel interfaces
// Valid/ready channels for the angle, the result and the term count.
// ----------------------------------------------------------------------------
interface smac_angle_if;
  logic                             valid;
  logic                             ready;
  logic [smac_pkg::ANGLE_W-1:0]     angle;

  modport source (output valid, output angle, input ready);
  modport sink   (input valid, input angle, output ready);
endinterface

interface smac_result_if;
  logic                             valid;
  logic                             ready;
  logic [smac_pkg::VALUE_W-1:0]     sine_value;
  logic                             saturated;

  modport source (output valid, output sine_value, output saturated, input ready);
  modport sink   (input valid, input sine_value, input saturated, output ready);
endinterface

interface smac_count_if;
  logic                             valid;
  logic                             ready;
  logic [smac_pkg::COUNT_W-1:0]     term_count;

  modport source (output valid, output term_count, input ready);
  modport sink   (input valid, input term_count, output ready);
endinterface

>>> rtl/sine_maclaurin_series.sv
`timescale 1ns / 1ps
// Series length: the term count clamped to MAX_TERMS; a count of zero goes
//   straight to rounding and gives zero.
// Requests: one at a time; the next is taken in the cycle after the result is
//   taken. Each 64x64 product runs setup, 4 passes of the one shared 32x32
//   multiplier, one drain and writeback; two products per term.
// Reset: synchronous, active high; term count returns to 8, block goes idle.
// ----------------------------------------------------------------------------
// sine_maclaurin_series
// Truncated Maclaurin sine series in Q.48 on a shared multi-cycle multiplier.
// ----------------------------------------------------------------------------
module sine_maclaurin_series #(
  parameter int MAX_TERMS = 16
) (
  input  logic                  clk,
  input  logic                  rst,
  smac_angle_if.sink            operand,
  smac_result_if.source         result,
  smac_count_if.sink            setup
);

  localparam int KW = $clog2(MAX_TERMS + 1);

  smac_pkg::state_t  state, state_next;
  smac_pkg::mul_op_t op, op_next;

  logic [smac_pkg::COUNT_W-1:0] term_count;
  logic [KW-1:0]                term_lim;
  logic [KW-1:0]                n, n_next, n_inc;
  logic [2:0]                   ph, ph_next;

  logic [smac_pkg::WORD_W-1:0]  x, x_next;
  logic [smac_pkg::WORD_W-1:0]  x2, x2_next;
  logic [smac_pkg::WORD_W-1:0]  term, term_next;
  logic [smac_pkg::WORD_W-1:0]  sum, sum_next;
  logic [smac_pkg::WORD_W-1:0]  opa, opa_next;
  logic [smac_pkg::WORD_W-1:0]  opb, opb_next;
  logic [smac_pkg::WORD_W-1:0]  ma, mb;
  logic                         neg;
  logic [smac_pkg::WORD_W-1:0]  pp;
  logic [smac_pkg::ACC_W-1:0]   acc, acc_next;
  logic [smac_pkg::VALUE_W-1:0] res_value, res_value_next;
  logic                         res_sat, res_sat_next;

  logic [smac_pkg::HALF_W-1:0]  a_half, b_half;
  logic [smac_pkg::WORD_W-1:0]  mul_prod;
  logic [smac_pkg::ACC_W-1:0]   addend;
  logic [smac_pkg::WORD_W-1:0]  mul_mag, mul_res;
  logic [smac_pkg::WORD_W-1:0]  sum_add, sum_sat;
  logic                         sum_ovf;
  logic [44:0]                  rnd;
  logic                         rnd_fits;
  logic [smac_pkg::WORD_W-1:0]  x_in, recip_word;

  assign term_lim = (32'(term_count) > MAX_TERMS) ? KW'(MAX_TERMS) : KW'(term_count);
  assign n_inc    = n + KW'(1);

  assign operand.ready     = (state == smac_pkg::S_IDLE);
  assign setup.ready       = 1'b1;
  assign result.valid      = (state == smac_pkg::S_OUT);
  assign result.sine_value = res_value;
  assign result.saturated  = res_sat;

  assign x_in = {{12{operand.angle[smac_pkg::ANGLE_W-1]}}, operand.angle,
                 {smac_pkg::ANGLE_SHIFT{1'b0}}};
  assign recip_word = {16'd0, smac_pkg::RECIP_Q48[smac_pkg::RECIP_IW'(n)]};

  // partial product order: a0*b0, a0*b1, a1*b0, a1*b1
  assign a_half   = (ph == 3'd2 || ph == 3'd3) ? ma[63:32] : ma[31:0];
  assign b_half   = (ph == 3'd1 || ph == 3'd3) ? mb[63:32] : mb[31:0];
  assign mul_prod = a_half * b_half;

  always_comb begin
    case (ph)
      3'd1:    addend = {64'd0, pp};
      3'd2:    addend = {32'd0, pp, 32'd0};
      3'd3:    addend = {32'd0, pp, 32'd0};
      3'd4:    addend = {pp, 64'd0};
      default: addend = '0;
    endcase
  end

  // truncate to 48 fraction bits, clamp magnitude, restore sign
  assign mul_mag = (|acc[127:111]) ? smac_pkg::MAG_LIMIT : {1'b0, acc[110:48]};
  assign mul_res = neg ? (~mul_mag + 64'd1) : mul_mag;

  assign sum_add = sum + term;
  assign sum_ovf = (sum[63] == term[63]) && (sum_add[63] != term[63]);
  assign sum_sat = sum_ovf ? (term[63] ? smac_pkg::WORD_MIN : smac_pkg::WORD_MAX) : sum_add;

  // floor(sum / 2^20 + 1/2)
  assign rnd      = {sum[63], sum[63:20]} + {44'd0, sum[smac_pkg::FRAC_SHIFT-1]};
  assign rnd_fits = (rnd[44:39] == 6'b000000) || (rnd[44:39] == 6'b111111);

  always_comb begin
    state_next     = state;
    op_next        = op;
    n_next         = n;
    ph_next        = ph;
    x_next         = x;
    x2_next        = x2;
    term_next      = term;
    sum_next       = sum;
    opa_next       = opa;
    opb_next       = opb;
    acc_next       = acc;
    res_value_next = res_value;
    res_sat_next   = res_sat;
    case (state)
      smac_pkg::S_IDLE: begin
        if (operand.valid) begin
          x_next   = x_in;
          opa_next = x_in;
          opb_next = x_in;
          op_next  = smac_pkg::OP_SQUARE;
          if (term_lim == '0) begin
            sum_next   = '0;
            state_next = smac_pkg::S_ROUND;
          end else begin
            state_next = smac_pkg::S_PREP;
          end
        end
      end
      smac_pkg::S_PREP: begin
        ph_next    = '0;
        acc_next   = '0;
        state_next = smac_pkg::S_MUL;
      end
      smac_pkg::S_MUL: begin
        acc_next = acc + addend;
        ph_next  = ph + 3'd1;
        if (ph == smac_pkg::MUL_LAST) begin
          state_next = smac_pkg::S_WB;
        end
      end
      smac_pkg::S_WB: begin
        case (op)
          smac_pkg::OP_SQUARE: begin
            x2_next   = mul_res;
            sum_next  = x;
            term_next = x;
            n_next    = KW'(1);
            if (term_lim > KW'(1)) begin
              opa_next   = x;
              opb_next   = mul_res;
              op_next    = smac_pkg::OP_XSQ;
              state_next = smac_pkg::S_PREP;
            end else begin
              state_next = smac_pkg::S_ROUND;
            end
          end
          smac_pkg::OP_XSQ: begin
            opa_next   = mul_res;
            opb_next   = recip_word;
            op_next    = smac_pkg::OP_RECIP;
            state_next = smac_pkg::S_PREP;
          end
          smac_pkg::OP_RECIP: begin
            term_next  = ~mul_res + 64'd1;
            state_next = smac_pkg::S_SUM;
          end
          default: begin
            state_next = smac_pkg::S_IDLE;
          end
        endcase
      end
      smac_pkg::S_SUM: begin
        sum_next = sum_sat;
        n_next   = n_inc;
        if (n_inc < term_lim) begin
          opa_next   = term;
          opb_next   = x2;
          op_next    = smac_pkg::OP_XSQ;
          state_next = smac_pkg::S_PREP;
        end else begin
          state_next = smac_pkg::S_ROUND;
        end
      end
      smac_pkg::S_ROUND: begin
        if (rnd_fits) begin
          res_value_next = rnd[39:0];
          res_sat_next   = 1'b0;
        end else begin
          res_value_next = rnd[44] ? smac_pkg::OUT_MIN : smac_pkg::OUT_MAX;
          res_sat_next   = 1'b1;
        end
        state_next = smac_pkg::S_OUT;
      end
      smac_pkg::S_OUT: begin
        if (result.ready) begin
          state_next = smac_pkg::S_IDLE;
        end
      end
      default: begin
        state_next = smac_pkg::S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= smac_pkg::S_IDLE;
      term_count <= smac_pkg::TERM_COUNT_RESET;
    end else begin
      state <= state_next;
      if (setup.valid) begin
        term_count <= setup.term_count;
      end
    end
  end

  always_ff @(posedge clk) begin
    op        <= op_next;
    n         <= n_next;
    ph        <= ph_next;
    x         <= x_next;
    x2        <= x2_next;
    term      <= term_next;
    sum       <= sum_next;
    opa       <= opa_next;
    opb       <= opb_next;
    acc       <= acc_next;
    res_value <= res_value_next;
    res_sat   <= res_sat_next;
    pp        <= mul_prod;
    // operand magnitudes latched ahead of the multiply passes
    if (state == smac_pkg::S_PREP) begin
      ma  <= opa[63] ? (~opa + 64'd1) : opa;
      mb  <= opb[63] ? (~opb + 64'd1) : opb;
      neg <= opa[63] ^ opb[63];
    end
  end

`ifndef SYNTHESIS
  a_sat_extreme: assert property (@(posedge clk) disable iff (rst)
    (result.valid && result.saturated) |->
      (result.sine_value == smac_pkg::OUT_MAX || result.sine_value == smac_pkg::OUT_MIN))
    else $error("saturated flag without a clipped value");

  a_zero_terms: assert property (@(posedge clk) disable iff (rst)
    (operand.valid && operand.ready && term_lim == '0) |-> ##2
      (result.valid && result.sine_value == '0 && !result.saturated))
    else $error("zero term count did not give zero");

  a_no_early_result: assert property (@(posedge clk) disable iff (rst)
    (operand.valid && operand.ready) |=> !result.valid)
    else $error("result shown right after request");

  a_phase_range: assert property (@(posedge clk) disable iff (rst)
    (state == smac_pkg::S_MUL) |-> (ph <= smac_pkg::MUL_LAST))
    else $error("multiply phase out of range");
`endif

endmodule

>>> tb/sv/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sine_maclaurin_series testbench
// Drives angles and term counts into the series evaluator, predicts each
// rounded and clipped sum in Q.48 arithmetic, and checks every result in order.
// ----------------------------------------------------------------------------
module testbench;

  localparam int LIMIT            = 3_000_000;
  localparam int RANDOM_PER_PHASE = 200;
  localparam int PHASES           = 10;
  localparam int HOLD_CYCLES      = 400;
  localparam int RANDOM_COUNT     = 32;
  localparam int TERM_LIMIT       = 16;

  localparam logic [63:0] PRODUCT_LIMIT = 64'h7FFF_FFFF_FFFF_FFFF;
  localparam logic [63:0] WORD_TOP      = 64'h7FFF_FFFF_FFFF_FFFF;
  localparam logic [63:0] WORD_BOTTOM   = 64'h8000_0000_0000_0000;
  localparam longint      SINE_TOP      = 64'sd549755813887;
  localparam longint      SINE_BOTTOM   = -64'sd549755813888;

  typedef struct packed {
    logic [39:0] value;
    logic        saturated;
  } sine_result_t;

  class sine_scoreboard;
    sine_result_t sine_queue[$];
    logic [4:0]   term_count;
    int           mismatches;

    function new();
      term_count = 5'd8;
      mismatches = 0;
    endfunction

    // product of two q.48 words, magnitude truncated, clipped at 2^63-1
    function logic [63:0] q48_product(logic [63:0] a, logic [63:0] b);
      logic [63:0]  ma;
      logic [63:0]  mb;
      logic [63:0]  m;
      logic [127:0] p;
      ma = a[63] ? -a : a;
      mb = b[63] ? -b : b;
      p = {64'd0, ma} * {64'd0, mb};
      if (p[127:111] != 17'd0) m = PRODUCT_LIMIT;
      else m = p[111:48];
      return (a[63] ^ b[63]) ? -m : m;
    endfunction

    function logic [63:0] reciprocal(int unsigned n);
      logic [63:0] d;
      d = 64'(2 * n) * 64'(2 * n + 1);
      return ((64'd1 << 48) + d / 2) / d;
    endfunction

    function logic [63:0] add_clipped(logic [63:0] s, logic [63:0] t);
      logic [63:0] r;
      r = s + t;
      if (s[63] == t[63] && r[63] != s[63]) r = s[63] ? WORD_BOTTOM : WORD_TOP;
      return r;
    endfunction

    function sine_result_t sine_series(logic [31:0] angle);
      logic [63:0]        x;
      logic [63:0]        x2;
      logic [63:0]        term;
      logic [63:0]        sum;
      logic signed [63:0] sum_s;
      longint             rounded;
      int unsigned        k;
      sine_result_t       res;
      x = {{32{angle[31]}}, angle} << 20;
      x2 = q48_product(x, x);
      k = (term_count > TERM_LIMIT) ? TERM_LIMIT : term_count;
      term = x;
      sum = 64'd0;
      for (int unsigned n = 0; n < k; n++) begin
        if (n > 0) term = -q48_product(q48_product(term, x2), reciprocal(n));
        sum = add_clipped(sum, term);
      end
      sum_s = sum;
      rounded = sum_s >>> 20;
      rounded = rounded + (sum_s[19] ? 1 : 0);
      res.saturated = 1'b0;
      if (rounded > SINE_TOP) begin
        rounded = SINE_TOP;
        res.saturated = 1'b1;
      end else if (rounded < SINE_BOTTOM) begin
        rounded = SINE_BOTTOM;
        res.saturated = 1'b1;
      end
      res.value = 40'(rounded);
      return res;
    endfunction

    function void note_angle(logic [31:0] angle);
      sine_queue.push_back(sine_series(angle));
    endfunction

    function void check_result(logic [39:0] value, logic saturated);
      sine_result_t want;
      if (sine_queue.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result: value %h saturated %b", value, saturated);
      end else begin
        want = sine_queue.pop_front();
        if (want.value !== value || want.saturated !== saturated) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: expected value %h saturated %b, got value %h saturated %b",
                     want.value, want.saturated, value, saturated);
        end
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst;

  smac_angle_if  operand_ch ();
  smac_result_if result_ch ();
  smac_count_if  setup_ch ();

  sine_maclaurin_series #(
    .MAX_TERMS (TERM_LIMIT)
  ) u_top (
    .clk       (clk),
    .rst       (rst),
    .operand   (operand_ch),
    .result    (result_ch),
    .setup     (setup_ch)
  );

  sine_scoreboard sb = new();

  bit tx_idle_en = 1'b1;
  bit rx_idle_en = 1'b1;
  bit hold_req   = 1'b0;
  int cycle_count = 0;

  always #1 clk = ~clk;

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count == LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  // receiver: takes results, stalls in bursts, and holds off for a long stretch on request
  initial begin
    int stall_left;
    int hold_left;
    stall_left = 0;
    hold_left = 0;
    result_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (!rst && result_ch.valid && result_ch.ready)
        sb.check_result(result_ch.sine_value, result_ch.saturated);
      if (hold_req) begin
        hold_req = 1'b0;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        result_ch.ready <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        result_ch.ready <= 1'b0;
      end else if (rx_idle_en && $urandom_range(0, 9) == 0) begin
        stall_left = $urandom_range(1, 19) - 1;
        result_ch.ready <= 1'b0;
      end else begin
        result_ch.ready <= 1'b1;
      end
    end
  end

  function automatic logic [31:0] random_angle();
    logic [31:0] a;
    case ($urandom_range(0, 9))
      6: begin
        a = $urandom_range(0, 32'h0010_0000);
        if ($urandom_range(0, 1) == 1) a = -a;
      end
      7: a = $signed($urandom) >>> 2;
      8: begin
        case ($urandom_range(0, 4))
          0: a = 32'h7FFF_FFFF;
          1: a = 32'h8000_0000;
          2: a = 32'h0000_0000;
          3: a = 32'h0000_0001;
          default: a = 32'hFFFF_FFFF;
        endcase
      end
      9: begin
        if ($urandom_range(0, 1) == 1) a = 32'h7FFF_FFFF - $urandom_range(0, 255);
        else a = 32'h8000_0000 + $urandom_range(0, 255);
      end
      default: a = $urandom;
    endcase
    return a;
  endfunction

  task automatic send_angle(input logic [31:0] a);
    int gap;
    gap = 0;
    if (tx_idle_en && $urandom_range(0, 3) == 0) gap = $urandom_range(1, 19);
    if (gap > 0) begin
      operand_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    operand_ch.valid <= 1'b1;
    operand_ch.angle <= a;
    do @(posedge clk); while (!operand_ch.ready);
    sb.note_angle(a);
  endtask

  task automatic finish_angles();
    operand_ch.valid <= 1'b0;
    while (sb.sine_queue.size() != 0) @(posedge clk);
  endtask

  task automatic write_term_count(input logic [4:0] c);
    setup_ch.valid <= 1'b1;
    setup_ch.term_count <= c;
    do @(posedge clk); while (!setup_ch.ready);
    sb.term_count = c;
    setup_ch.valid <= 1'b0;
  endtask

  initial begin
    logic [31:0] directed_angles [13] = '{
      32'h0000_0000, 32'h0000_0001, 32'hFFFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000,
      32'd421657428, -32'd421657428, 32'd843314857, 32'h1000_0000, 32'hF000_0000,
      32'h5555_5555, 32'hAAAA_AAAA, 32'h0000_3039
    };
    int phase_counts [PHASES] = '{16, 0, 1, 31, 2, 17, 5, RANDOM_COUNT, RANDOM_COUNT, 8};
    int count;

    rst = 1'b1;
    operand_ch.valid <= 1'b0;
    operand_ch.angle <= '0;
    setup_ch.valid <= 1'b0;
    setup_ch.term_count <= '0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // reset term count first, then zero terms and a count above the limit
    foreach (directed_angles[i]) send_angle(directed_angles[i]);
    finish_angles();
    write_term_count(5'd0);
    send_angle(32'h7FFF_FFFF);
    send_angle(32'h8000_0000);
    send_angle(32'h0000_3039);
    finish_angles();
    write_term_count(5'd31);
    send_angle(32'h7FFF_FFFF);
    send_angle(32'h8000_0000);
    send_angle(32'd421657428);
    finish_angles();

    for (int p = 0; p < PHASES; p++) begin
      count = phase_counts[p];
      if (count == RANDOM_COUNT) count = $urandom_range(0, 31);
      if (p == PHASES - 1) begin
        tx_idle_en = 1'b0;
        rx_idle_en = 1'b0;
      end
      write_term_count(5'(count));
      // long receiver hold-off so requests back up behind a finished result
      if (p == 3) hold_req = 1'b1;
      for (int i = 0; i < RANDOM_PER_PHASE; i++) send_angle(random_angle());
      finish_angles();
    end

    repeat (40) @(posedge clk);
    if (sb.mismatches == 0 && sb.sine_queue.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
